// ===== rtl/vml_pkg.sv =====
// vml_pkg: widths, constants and request/lane sideband types for the
// vector magnitude limit unit. No dependencies.
`timescale 1ns / 1ps
package vml_pkg;

   localparam int CW  = 16;          // component width
   localparam int LW  = CW - 1;      // limit register width
   localparam int SQW = 2 * CW;      // squared length width
   localparam int RW  = CW;          // root width
   localparam int QW  = CW;          // quotient width
   localparam int DW  = 2 * CW - 1;  // scaled dividend width

   localparam logic [LW-1:0] LIMIT_RESET = {LW{1'b1}};

   typedef logic [CW-1:0] comp_type;

   typedef struct packed {
      logic           valid;
      comp_type       x;
      comp_type       y;
      logic [DW-1:0]  nx;
      logic [DW-1:0]  ny;
      logic           limited;
   } side_type;

   typedef struct packed {
      logic     valid;
      comp_type raw;
      logic     limited;
   } lane_side_type;

endpackage

// ===== rtl/vml_isqrt.sv =====
// vml_isqrt: pipelined floor square root, one result bit per stage.
// Depends on vml_pkg.
`timescale 1ns / 1ps
module vml_isqrt
   import vml_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [SQW-1:0]  sq,
   input  side_type        side_in,
   output logic [RW-1:0]   root,
   output side_type        side_out
);

   logic [SQW-1:0] v_st   [RW+1];
   logic [SQW-1:0] res_st [RW+1];
   side_type       sd_st  [RW+1];
   logic [SQW-1:0] v_ff   [RW];
   logic [SQW-1:0] res_ff [RW];
   side_type       sd_ff  [RW];

   assign v_st[0]   = sq;
   assign res_st[0] = '0;
   assign sd_st[0]  = side_in;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (RW - 1 - k));
      logic [SQW-1:0] trial;
      logic [SQW-1:0] v_in;
      logic [SQW-1:0] res_in;

      always_comb begin
         trial = res_st[k] + BIT;
         if (v_st[k] >= trial) begin
            v_in   = v_st[k] - trial;
            res_in = (res_st[k] >> 1) + BIT;
         end else begin
            v_in   = v_st[k];
            res_in = res_st[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[k]   <= v_in;
         res_ff[k] <= res_in;
         if (reset) begin
            sd_ff[k].valid <= 1'b0;
         end else begin
            sd_ff[k] <= sd_st[k];
         end
      end

      assign v_st[k+1]   = v_ff[k];
      assign res_st[k+1] = res_ff[k];
      assign sd_st[k+1]  = sd_ff[k];
   end

   assign root     = res_st[RW][RW-1:0];
   assign side_out = sd_st[RW];

endmodule

// ===== rtl/vml_div_lane.sv =====
// vml_div_lane: one pipelined restoring divider lane, one quotient bit
// per stage, scaling a single component. Depends on vml_pkg.
`timescale 1ns / 1ps
module vml_div_lane
   import vml_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [DW-1:0]   dividend,
   input  logic [RW-1:0]   divisor,
   input  lane_side_type   side_in,
   output logic [QW-1:0]   quotient,
   output lane_side_type   side_out
);

   logic [RW-1:0]  rem_st [QW+1];
   logic [QW-1:0]  num_st [QW+1];
   logic [QW-1:0]  q_st   [QW+1];
   logic [RW-1:0]  d_st   [QW+1];
   lane_side_type  sd_st  [QW+1];
   logic [RW-1:0]  rem_ff [QW];
   logic [QW-1:0]  num_ff [QW];
   logic [QW-1:0]  q_ff   [QW];
   logic [RW-1:0]  d_ff   [QW];
   lane_side_type  sd_ff  [QW];

   assign rem_st[0] = RW'(dividend[DW-1:QW]);
   assign num_st[0] = dividend[QW-1:0];
   assign q_st[0]   = '0;
   assign d_st[0]   = divisor;
   assign sd_st[0]  = side_in;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [RW:0]   r2;
      logic [RW-1:0] rem_in;
      logic          qbit;

      always_comb begin
         r2 = {rem_st[k], num_st[k][QW-1]};
         if (r2 >= {1'b0, d_st[k]}) begin
            qbit   = 1'b1;
            rem_in = RW'(r2 - {1'b0, d_st[k]});
         end else begin
            qbit   = 1'b0;
            rem_in = r2[RW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         num_ff[k] <= num_st[k] << 1;
         q_ff[k]   <= {q_st[k][QW-2:0], qbit};
         d_ff[k]   <= d_st[k];
         if (reset) begin
            sd_ff[k].valid <= 1'b0;
         end else begin
            sd_ff[k] <= sd_st[k];
         end
      end

      assign rem_st[k+1] = rem_ff[k];
      assign num_st[k+1] = num_ff[k];
      assign q_st[k+1]   = q_ff[k];
      assign d_st[k+1]   = d_ff[k];
      assign sd_st[k+1]  = sd_ff[k];
   end

   assign quotient = q_st[QW];
   assign side_out = sd_st[QW];

endmodule

// ===== rtl/vector_magnitude_limit_unit.sv =====
// vector_magnitude_limit_unit: top level, clamps the length of a 2-D vector.
// Uses vml_pkg, vml_isqrt and two vml_div_lane instances.
//
// Usage:
//   request: drive req_x_in and req_y_in and raise start; the request is taken
//   at any rising edge with start high and busy low. busy is always low, so a
//   new request may be given every cycle.
//   result: rsp_x_out, rsp_y_out and rsp_was_limited appear for one cycle with
//   rsp_strobe high. After the magnitude, product and compare registers, the
//   request passes the square root pipeline (one root bit a stage), then the
//   divider lanes (one quotient bit a stage), then the output register.
//   Throughput is one request per clock.
//   config: csr_write_en with csr_write_data sets the length limit; write it
//   only while no request is in flight.
//   reset: synchronous, active high; flushes all requests in flight and
//   sets the limit to its maximum. The receiver cannot stall the results.
`timescale 1ns / 1ps
module vector_magnitude_limit_unit
   import vml_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CW-1:0]     req_x_in,
   input  logic [CW-1:0]     req_y_in,
   input  logic              csr_write_en,
   input  logic [LW-1:0]     csr_write_data,
   output logic              rsp_strobe,
   output logic [CW-1:0]     rsp_x_out,
   output logic [CW-1:0]     rsp_y_out,
   output logic              rsp_was_limited
);

   logic [LW-1:0]    limit_ff;
   logic             a_valid_ff;
   comp_type         a_x_ff, a_y_ff;
   logic [CW-1:0]    a_ax_ff, a_ay_ff;
   logic [LW-1:0]    a_lim_ff;
   logic             b_valid_ff;
   comp_type         b_x_ff, b_y_ff;
   logic [SQW-2:0]   b_axsq_ff, b_aysq_ff;
   logic [SQW-3:0]   b_limsq_ff;
   logic [DW-1:0]    b_nx_ff, b_ny_ff;
   logic [SQW-1:0]   c_sq_ff;
   side_type         c_side_ff;
   logic [RW-1:0]    root;
   side_type         root_side;
   lane_side_type    lx_in, ly_in, lx_out, ly_out;
   logic [QW-1:0]    qx, qy;
   logic             rsp_strobe_ff;
   logic [CW-1:0]    rsp_x_ff, rsp_y_ff;
   logic             rsp_lim_ff;
   logic [CW-1:0]    x_out_in, y_out_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_en) begin
         limit_ff <= csr_write_data;
      end
   end

   // magnitudes
   always_ff @(posedge clock) begin
      a_valid_ff <= reset ? 1'b0 : (start && !busy);
      a_x_ff     <= req_x_in;
      a_y_ff     <= req_y_in;
      a_ax_ff    <= req_x_in[CW-1] ? (~req_x_in + CW'(1)) : req_x_in;
      a_ay_ff    <= req_y_in[CW-1] ? (~req_y_in + CW'(1)) : req_y_in;
      a_lim_ff   <= limit_ff;
   end

   // products
   always_ff @(posedge clock) begin
      b_valid_ff <= reset ? 1'b0 : a_valid_ff;
      b_x_ff     <= a_x_ff;
      b_y_ff     <= a_y_ff;
      b_axsq_ff  <= (SQW-1)'(a_ax_ff * a_ax_ff);
      b_aysq_ff  <= (SQW-1)'(a_ay_ff * a_ay_ff);
      b_limsq_ff <= (SQW-2)'(a_lim_ff * a_lim_ff);
      b_nx_ff    <= DW'(a_ax_ff * a_lim_ff);
      b_ny_ff    <= DW'(a_ay_ff * a_lim_ff);
   end

   // squared length and compare
   always_ff @(posedge clock) begin
      c_sq_ff           <= SQW'(b_axsq_ff) + SQW'(b_aysq_ff);
      c_side_ff.x       <= b_x_ff;
      c_side_ff.y       <= b_y_ff;
      c_side_ff.nx      <= b_nx_ff;
      c_side_ff.ny      <= b_ny_ff;
      c_side_ff.limited <= (SQW'(b_axsq_ff) + SQW'(b_aysq_ff)) > SQW'(b_limsq_ff);
      c_side_ff.valid   <= reset ? 1'b0 : b_valid_ff;
   end

   vml_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .sq       (c_sq_ff),
      .side_in  (c_side_ff),
      .root     (root),
      .side_out (root_side)
   );

   assign lx_in = '{valid: root_side.valid, raw: root_side.x, limited: root_side.limited};
   assign ly_in = '{valid: root_side.valid, raw: root_side.y, limited: root_side.limited};

   vml_div_lane u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .dividend (root_side.nx),
      .divisor  (root),
      .side_in  (lx_in),
      .quotient (qx),
      .side_out (lx_out)
   );

   vml_div_lane u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .dividend (root_side.ny),
      .divisor  (root),
      .side_in  (ly_in),
      .quotient (qy),
      .side_out (ly_out)
   );

   // merge lanes and restore signs
   always_comb begin
      if (lx_out.limited) begin
         x_out_in = lx_out.raw[CW-1] ? (~qx + CW'(1)) : qx;
         y_out_in = ly_out.raw[CW-1] ? (~qy + CW'(1)) : qy;
      end else begin
         x_out_in = lx_out.raw;
         y_out_in = ly_out.raw;
      end
   end

   always_ff @(posedge clock) begin
      rsp_strobe_ff <= reset ? 1'b0 : lx_out.valid;
      rsp_x_ff      <= x_out_in;
      rsp_y_ff      <= y_out_in;
      rsp_lim_ff    <= lx_out.limited;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_x_out       = rsp_x_ff;
   assign rsp_y_out       = rsp_y_ff;
   assign rsp_was_limited = rsp_lim_ff;

   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      lx_out.valid == ly_out.valid &&
      (!lx_out.valid || lx_out.limited == ly_out.limited))
      else $error("divider lanes out of step");

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      root_side.valid && root_side.limited |-> root != '0)
      else $error("zero root on a limited request");

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      lx_out.valid && !lx_out.limited |=> rsp_x_out == $past(lx_out.raw))
      else $error("unlimited request altered");

endmodule
